>>> rtl/amgs_pkg.sv
// Package for the adjacency matrix graph store: sizes, request codes, CSR indices, types.
// No dependencies.
package amgs_pkg;
   localparam int MAX_VERTICES = 16;
   localparam int COUNT_BITS   = 8;
   localparam int VBITS        = $clog2(MAX_VERTICES);
   localparam int NBITS        = $clog2(MAX_VERTICES + 1);
   localparam int TBITS        = COUNT_BITS + 1;
   localparam int PBITS        = 2 * VBITS;

   localparam logic [2:0] REQ_ADD   = 3'd0;
   localparam logic [2:0] REQ_LINK  = 3'd1;
   localparam logic [2:0] REQ_DEG   = 3'd2;
   localparam logic [2:0] REQ_SUCC  = 3'd3;
   localparam logic [2:0] REQ_PRED  = 3'd4;
   localparam logic [2:0] REQ_NEIGH = 3'd5;
   localparam logic [2:0] REQ_FIRST = 3'd6;
   localparam logic [2:0] REQ_NEXT  = 3'd7;

   localparam logic [0:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [0:0] CSR_DIRECTED     = 1'd1;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [VBITS-1:0] vertex_a;
      logic [VBITS-1:0] vertex_b;
      logic [PBITS-1:0] edge_index;
   } req_type_t_type;

   typedef struct packed {
      logic                  status;
      logic                  found;
      logic [VBITS-1:0]      vertex;
      logic [COUNT_BITS-1:0] in_degree;
      logic [COUNT_BITS-1:0] out_degree;
      logic [TBITS-1:0]      total_degree;
      logic [COUNT_BITS-1:0] max_in_degree;
      logic [COUNT_BITS-1:0] max_out_degree;
      logic [TBITS-1:0]      max_total_degree;
      logic [VBITS-1:0]      edge_source;
      logic [VBITS-1:0]      edge_dest;
      logic                  last;
   } rsp_payload_type;
endpackage

>>> rtl/amgs_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on amgs_pkg.
interface amgs_req_if import amgs_pkg::*; ();
   logic           valid;
   logic           ready;
   req_type_t_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface amgs_rsp_if import amgs_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/adjacency_matrix_graph_store_core.sv
// Adjacency matrix graph store: one request at a time under a sequencer.
// Add: counter updates, more when an undirected edge is mirrored, then maxima. Link query:
// answered from idle; degree query: via the emit state. Listing: one scan pass (two for
// directed neighbors). Edge search: one matrix position per cycle, up to n*n; next-edge
// first splits edge_index. The next request waits until the response register is empty.
// Synchronous active-high reset clears matrix, counters, maxima; registers to 16/1.
module adjacency_matrix_graph_store_core import amgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   amgs_req_if.sink    req,
   amgs_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_ADD, S_MAX, S_LIST, S_SCAN, S_EMIT, S_WAIT, S_DIV
   } state_type;

   localparam logic [COUNT_BITS-1:0] TOP = {COUNT_BITS{1'b1}};

   state_type state_ff;
   logic [MAX_VERTICES-1:0] adj_ff [MAX_VERTICES];
   logic [COUNT_BITS-1:0]   inc_ff [MAX_VERTICES];
   logic [COUNT_BITS-1:0]   outc_ff [MAX_VERTICES];
   logic [COUNT_BITS-1:0]   max_in_ff, max_out_ff;
   logic [TBITS-1:0]        max_tot_ff;
   logic [4:0]              vcount_ff;
   logic                    directed_ff;
   req_type_t_type          cur_ff;
   logic [VBITS-1:0]        row_ff, col_ff;
   logic [PBITS-1:0]        rem_ff;
   logic [1:0]              step_ff;
   logic                    pass_ff, any_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_ff;

   // active vertex count, clamped
   logic [NBITS-1:0] n;
   assign n = (vcount_ff > 5'(MAX_VERTICES)) ? NBITS'(MAX_VERTICES) : NBITS'(vcount_ff);

   logic [NBITS-1:0] lastv;
   assign lastv = n - NBITS'(1);

   // listing candidate at col_ff
   logic rowbit, colbit, hit_list;
   assign rowbit = adj_ff[cur_ff.vertex_a][col_ff];
   assign colbit = adj_ff[col_ff][cur_ff.vertex_a];
   always_comb begin
      case (cur_ff.req_type)
         REQ_SUCC: hit_list = rowbit;
         REQ_PRED: hit_list = colbit;
         default:  hit_list = pass_ff ? (colbit && !rowbit) : rowbit;
      endcase
   end

   // next listing hit ahead, to flag last: scan remaining once per cycle is
   // avoided by holding one found item and emitting it when the next is seen
   logic       pend_ff;
   logic [VBITS-1:0] pend_v_ff;

   logic scan_bit;
   assign scan_bit = adj_ff[row_ff][col_ff];
   logic row_end, col_end;
   assign col_end = ({1'b0, col_ff} == lastv);
   assign row_end = ({1'b0, row_ff} == lastv);

   // shared saturating increment
   logic [COUNT_BITS-1:0] inc_src, inc_res;
   assign inc_res = (inc_src == TOP) ? TOP : inc_src + COUNT_BITS'(1);

   // shared total degree of a vertex
   logic [VBITS-1:0] tv;
   logic [TBITS-1:0] tot;
   assign tot = directed_ff ? (TBITS'(inc_ff[tv]) + TBITS'(outc_ff[tv]))
                            : (TBITS'(outc_ff[tv]) + TBITS'(adj_ff[tv][tv]));

   logic [VBITS-1:0] sa, sb;
   logic             mirror;
   assign mirror = !directed_ff && (cur_ff.vertex_a != cur_ff.vertex_b);
   always_comb begin
      sa = cur_ff.vertex_a; sb = cur_ff.vertex_b;
      if (step_ff[0]) begin sa = cur_ff.vertex_b; sb = cur_ff.vertex_a; end
      case (step_ff[1])
         1'b0:    inc_src = outc_ff[sa];
         default: inc_src = inc_ff[sb];
      endcase
      tv = step_ff[0] ? cur_ff.vertex_b : cur_ff.vertex_a;
   end

   logic req_bad, idx_bad;
   assign req_bad = (req.data.req_type <= REQ_NEIGH) &&
                    (({1'b0, req.data.vertex_a} >= n) ||
                     ((req.data.req_type <= REQ_LINK) && ({1'b0, req.data.vertex_b} >= n)));
   assign idx_bad = ({1'b0, req.data.edge_index} >= ((PBITS+1)'(n) * (PBITS+1)'(n)));

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // base response: maxima filled, last set, everything else zero
   function automatic rsp_payload_type base_rsp(input logic [COUNT_BITS-1:0] mi,
         input logic [COUNT_BITS-1:0] mo, input logic [TBITS-1:0] mt);
      rsp_payload_type r;
      r = '0;
      r.max_in_degree = mi; r.max_out_degree = mo; r.max_total_degree = mt;
      r.last = 1'b1;
      return r;
   endfunction

   // hold state, matrix, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_ff[i] <= '0; inc_ff[i] <= '0; outc_ff[i] <= '0;
         end
         max_in_ff <= '0; max_out_ff <= '0; max_tot_ff <= '0;
         vcount_ff <= 5'd16; directed_ff <= 1'b1;
         pend_ff <= 1'b0; any_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_VERTEX_COUNT: vcount_ff <= csr_data;
               default:          directed_ff <= csr_data[0];
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cur_ff <= req.data;
                  step_ff <= '0; pass_ff <= 1'b0; any_ff <= 1'b0; pend_ff <= 1'b0;
                  col_ff <= '0; row_ff <= '0;
                  rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                  if (req_bad || (req.data.req_type == REQ_NEXT && idx_bad) ||
                      (req.data.req_type == REQ_FIRST && n == '0)) begin
                     rsp_ff.status <= (req.data.req_type != REQ_FIRST);
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     case (req.data.req_type)
                        REQ_ADD: begin
                           adj_ff[req.data.vertex_a][req.data.vertex_b] <= 1'b1;
                           state_ff <= S_ADD;
                        end
                        REQ_LINK: begin
                           rsp_ff.found <=
                              adj_ff[req.data.vertex_a][req.data.vertex_b];
                           rsp_valid_ff <= 1'b1;
                        end
                        REQ_DEG: state_ff <= S_EMIT;
                        REQ_FIRST: state_ff <= S_SCAN;
                        REQ_NEXT: begin
                           // split edge_index into row and column first
                           rem_ff <= req.data.edge_index;
                           state_ff <= S_DIV;
                        end
                        default: state_ff <= S_LIST;
                     endcase
                  end
               end
            end
            S_ADD: begin
               // step 0: out[a], 2: in[b], 1: out[b], 3: in[a] (mirror)
               case (step_ff[1])
                  1'b0:    outc_ff[sa] <= inc_res;
                  default: inc_ff[sb] <= inc_res;
               endcase
               if (step_ff == 2'd0 && mirror) adj_ff[cur_ff.vertex_b][cur_ff.vertex_a] <= 1'b1;
               if (step_ff == 2'd0)      step_ff <= 2'd2;
               else if (step_ff == 2'd2) step_ff <= mirror ? 2'd1 : 2'd0;
               else if (step_ff == 2'd1) step_ff <= 2'd3;
               else                      step_ff <= 2'd0;
               if ((step_ff == 2'd2 && !mirror) || step_ff == 2'd3) begin
                  step_ff <= 2'd0;
                  state_ff <= S_MAX;
               end
            end
            S_MAX: begin
               // raise maxima by a, then b
               if (inc_ff[tv] > max_in_ff)  max_in_ff  <= inc_ff[tv];
               if (outc_ff[tv] > max_out_ff) max_out_ff <= outc_ff[tv];
               if (tot > max_tot_ff)         max_tot_ff <= tot;
               if (step_ff[0]) begin
                  state_ff <= S_EMIT;
               end else step_ff <= 2'd1;
            end
            S_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                  if (cur_ff.req_type == REQ_DEG) begin
                     rsp_ff.in_degree  <= inc_ff[cur_ff.vertex_a];
                     rsp_ff.out_degree <= outc_ff[cur_ff.vertex_a];
                     rsp_ff.total_degree <= tot;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               // subtract n once per cycle; the count is the row, the rest the column
               if (rem_ff >= PBITS'(n)) begin
                  rem_ff <= rem_ff - PBITS'(n);
                  row_ff <= row_ff + VBITS'(1);
               end else begin
                  col_ff <= rem_ff[VBITS-1:0];
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               // advance one position past edge_index
               if (col_end) begin
                  col_ff <= directed_ff ? '0 : row_ff + VBITS'(1);
                  row_ff <= row_ff + VBITS'(1);
                  if (row_end) begin
                     rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else state_ff <= S_SCAN;
               end else begin
                  col_ff <= col_ff + VBITS'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_bit) begin
                  rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                  rsp_ff.found <= 1'b1;
                  rsp_ff.edge_source <= row_ff;
                  rsp_ff.edge_dest <= col_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (col_end) begin
                  if (row_end) begin
                     rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     row_ff <= row_ff + VBITS'(1);
                     col_ff <= directed_ff ? '0 : row_ff + VBITS'(1);
                  end
               end else col_ff <= col_ff + VBITS'(1);
            end
            S_LIST: begin
               if (any_ff) begin
                  // final listing transfer: pending hit as last, or empty listing
                  if (!rsp_valid_ff) begin
                     rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                     rsp_ff.found <= pend_ff;
                     rsp_ff.vertex <= pend_ff ? pend_v_ff : '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else if (!(pend_ff && hit_list && rsp_valid_ff)) begin
                  // hold one pending hit; emit it as non-last when the next appears
                  if (hit_list) begin
                     if (pend_ff) begin
                        rsp_ff <= base_rsp(max_in_ff, max_out_ff, max_tot_ff);
                        rsp_ff.found <= 1'b1;
                        rsp_ff.vertex <= pend_v_ff;
                        rsp_ff.last <= 1'b0;
                        rsp_valid_ff <= 1'b1;
                     end
                     pend_ff <= 1'b1;
                     pend_v_ff <= col_ff;
                  end
                  if (col_end) begin
                     col_ff <= '0;
                     if (cur_ff.req_type == REQ_NEIGH && directed_ff && !pass_ff)
                        pass_ff <= 1'b1;
                     else any_ff <= 1'b1;
                  end else col_ff <= col_ff + VBITS'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> dv/adjacency_matrix_graph_store_core_tb.sv
// Self-checking testbench for the adjacency matrix graph store core.
// Depends on amgs_pkg, amgs_if and the core; predicts every response from a local graph copy.
module adjacency_matrix_graph_store_core_tb;
   import amgs_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [4:0] csr_data;

   amgs_req_if req_ch ();
   amgs_rsp_if rsp_ch ();

   adjacency_matrix_graph_store_core uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow graph
   logic [15:0]           adj_shadow [16];
   logic [COUNT_BITS-1:0] in_shadow  [16];
   logic [COUNT_BITS-1:0] out_shadow [16];
   logic [COUNT_BITS-1:0] peak_in;
   logic [COUNT_BITS-1:0] peak_out;
   logic [TBITS-1:0]      peak_total;
   logic [4:0]            vcount_shadow;
   logic                  directed_shadow;

   req_type_t_type  pending_reqs [$];
   rsp_payload_type expected_rsps [$];
   int  errors;
   int  req_sent;
   int  rsp_seen;
   int  req_gap;
   int  rsp_gap;
   bit  quiet;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic logic [TBITS-1:0] degree_sum(int v);
      if (directed_shadow) return TBITS'(in_shadow[v]) + TBITS'(out_shadow[v]);
      return TBITS'(out_shadow[v]) + TBITS'(adj_shadow[v][v]);
   endfunction

   function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic void raise_peaks(int v);
      logic [TBITS-1:0] t;
      t = degree_sum(v);
      if (in_shadow[v] > peak_in) peak_in = in_shadow[v];
      if (out_shadow[v] > peak_out) peak_out = out_shadow[v];
      if (t > peak_total) peak_total = t;
   endfunction

   function automatic rsp_payload_type blank_rsp();
      rsp_payload_type r;
      r = '0;
      r.max_in_degree = peak_in;
      r.max_out_degree = peak_out;
      r.max_total_degree = peak_total;
      r.last = 1'b1;
      return r;
   endfunction

   // Append one predicted response.
   function automatic void queue_rsp(rsp_payload_type r);
      expected_rsps = {expected_rsps, r};
   endfunction

   // Search edges from row r0/column c0 (upper triangle when undirected).
   function automatic bit find_edge(int n, int r0, int c0, output int rs, output int cs);
      rs = 0; cs = 0;
      for (int r = r0; r < n; r++) begin
         for (int c = (r == r0) ? c0 : (directed_shadow ? 0 : r); c < n; c++) begin
            if (adj_shadow[r][c]) begin
               rs = r; cs = c;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Update the shadow graph and queue the responses one request causes.
   task automatic predict_graph_op(req_type_t_type q);
      rsp_payload_type r;
      int n, a, b, cur, rs, cs, cnt;
      int names [$];
      bit hit;
      n = (vcount_shadow > 16) ? 16 : vcount_shadow;
      a = q.vertex_a; b = q.vertex_b; cur = q.edge_index;
      if (q.req_type <= REQ_NEIGH && (a >= n || (q.req_type <= REQ_LINK && b >= n))) begin
         r = blank_rsp(); r.status = 1'b1;
         queue_rsp(r);
         return;
      end
      case (q.req_type)
         REQ_ADD: begin
            adj_shadow[a][b] = 1'b1;
            out_shadow[a] = bump(out_shadow[a]);
            in_shadow[b] = bump(in_shadow[b]);
            if (!directed_shadow && a != b) begin
               adj_shadow[b][a] = 1'b1;
               out_shadow[b] = bump(out_shadow[b]);
               in_shadow[a] = bump(in_shadow[a]);
            end
            raise_peaks(a);
            raise_peaks(b);
            queue_rsp(blank_rsp());
         end
         REQ_LINK: begin
            r = blank_rsp(); r.found = adj_shadow[a][b];
            queue_rsp(r);
         end
         REQ_DEG: begin
            r = blank_rsp();
            r.in_degree = in_shadow[a];
            r.out_degree = out_shadow[a];
            r.total_degree = degree_sum(a);
            queue_rsp(r);
         end
         REQ_SUCC, REQ_PRED, REQ_NEIGH: begin
            for (int i = 0; i < n; i++)
               if ((q.req_type == REQ_PRED) ? adj_shadow[i][a] : adj_shadow[a][i])
                  names = {names, i};
            if (q.req_type == REQ_NEIGH && directed_shadow)
               for (int i = 0; i < n; i++)
                  if (adj_shadow[i][a] && !adj_shadow[a][i]) names = {names, i};
            cnt = names.size();
            if (cnt == 0) queue_rsp(blank_rsp());
            for (int i = 0; i < cnt; i++) begin
               r = blank_rsp();
               r.found = 1'b1;
               r.vertex = VBITS'(names[i]);
               r.last = (i == cnt - 1);
               queue_rsp(r);
            end
         end
         default: begin
            r = blank_rsp();
            if (q.req_type == REQ_NEXT && cur >= n * n) begin
               r.status = 1'b1;
               queue_rsp(r);
               return;
            end
            if (q.req_type == REQ_FIRST) hit = find_edge(n, 0, 0, rs, cs);
            else if (directed_shadow) begin
               // linear scan from cur+1
               if ((cur + 1) % n == 0) hit = find_edge(n, (cur + 1) / n, 0, rs, cs);
               else hit = find_edge(n, (cur + 1) / n, (cur + 1) % n, rs, cs);
            end else hit = find_edge(n, cur / n, cur % n + 1, rs, cs);
            if (hit) begin
               r.found = 1'b1;
               r.edge_source = VBITS'(rs);
               r.edge_dest = VBITS'(cs);
            end
            queue_rsp(r);
         end
      endcase
   endtask

   // Driver: present queued requests, idle in bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_graph_op(req_ch.data);
            void'(pending_reqs.pop_front());
            req_sent <= req_sent + 1;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               req_gap <= $urandom_range(1, 15) - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.data <= pending_reqs[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch, expected %h, actual %h", $time, want, got);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_gap <= $urandom_range(1, 15) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic push_req(logic [2:0] kind, int a, int b, int idx);
      req_type_t_type q;
      q.req_type = kind;
      q.vertex_a = VBITS'(a);
      q.vertex_b = VBITS'(b);
      q.edge_index = PBITS'(idx);
      pending_reqs = {pending_reqs, q};
   endtask

   // Mostly in-range random traffic, weighted toward adds.
   task automatic push_random(int cnt, int n);
      int k, lim;
      for (int i = 0; i < cnt; i++) begin
         k = $urandom_range(0, 9);
         lim = ($urandom_range(0, 7) == 0) ? 15 : n - 1;
         push_req(k < 3 ? REQ_ADD : 3'(k - 2), $urandom_range(0, lim),
                  $urandom_range(0, lim),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, n * n - 1));
      end
   endtask

   // Wait until all queued work has drained, then settle.
   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [4:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx == CSR_VERTEX_COUNT) vcount_shadow = val;
      else directed_shadow = val[0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int settings_n [4];
      bit settings_d [4];
      errors = 0; req_sent = 0; rsp_seen = 0; quiet = 0;
      reset = 1'b1; csr_write = 1'b0; csr_index = '0; csr_data = '0;
      req_ch.valid = 1'b0; req_ch.data = '0; rsp_ch.ready = 1'b0;
      for (int i = 0; i < 16; i++) begin
         adj_shadow[i] = '0; in_shadow[i] = '0; out_shadow[i] = '0;
      end
      peak_in = '0; peak_out = '0; peak_total = '0;
      vcount_shadow = 5'd16; directed_shadow = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed checks on the reset configuration
      push_req(REQ_FIRST, 0, 0, 0);
      push_req(REQ_SUCC, 0, 0, 0);
      push_req(REQ_ADD, 0, 15, 0);
      push_req(REQ_ADD, 15, 0, 0);
      push_req(REQ_ADD, 3, 3, 0);
      push_req(REQ_ADD, 3, 3, 0);
      push_req(REQ_ADD, 5, 3, 0);
      push_req(REQ_LINK, 0, 15, 0);
      push_req(REQ_LINK, 15, 15, 0);
      push_req(REQ_DEG, 3, 0, 0);
      push_req(REQ_SUCC, 3, 0, 0);
      push_req(REQ_PRED, 3, 0, 0);
      push_req(REQ_NEIGH, 3, 0, 0);
      push_req(REQ_NEIGH, 9, 0, 0);
      push_req(REQ_FIRST, 0, 0, 0);
      push_req(REQ_NEXT, 0, 0, 15);
      push_req(REQ_NEXT, 0, 0, 255);
      push_req(REQ_NEXT, 0, 0, 254);
      for (int i = 0; i < 3; i++) push_req(REQ_ADD, 1, 2, 0);
      drain();

      // saturate one counter pair, then shrink and go undirected
      for (int i = 0; i < 256; i++) push_req(REQ_ADD, 7, 8, 0);
      push_req(REQ_DEG, 7, 0, 0);
      push_req(REQ_DEG, 8, 0, 0);
      drain();
      write_csr(CSR_VERTEX_COUNT, 5'd4);
      write_csr(CSR_DIRECTED, 5'd0);
      push_req(REQ_ADD, 4, 0, 0);
      push_req(REQ_ADD, 0, 2, 0);
      push_req(REQ_ADD, 2, 2, 0);
      push_req(REQ_NEIGH, 2, 0, 0);
      push_req(REQ_DEG, 2, 0, 0);
      push_req(REQ_FIRST, 0, 0, 0);
      push_req(REQ_NEXT, 0, 0, 2);
      push_req(REQ_NEXT, 0, 0, 16);
      drain();
      write_csr(CSR_VERTEX_COUNT, 5'd0);
      push_req(REQ_FIRST, 0, 0, 0);
      push_req(REQ_NEXT, 0, 0, 0);
      push_req(REQ_ADD, 0, 0, 0);
      drain();

      // random phases across several settings
      settings_n = '{1, 16, 31, 9};
      settings_d = '{1, 0, 1, 0};
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_VERTEX_COUNT, 5'(settings_n[p]));
         write_csr(CSR_DIRECTED, 5'(settings_d[p]));
         if (p == 3) quiet = 1;
         push_random(p == 0 ? 6 : 10, settings_n[p] > 16 ? 16 : settings_n[p]);
         drain();
      end

      $display("Covered %0d requests and %0d responses across directed and undirected graphs,",
               req_sent, rsp_seen);
      $display("vertex counts 0 to 31, counter saturation and edge search wraparound.");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

>>> sim.f
rtl/amgs_pkg.sv
rtl/amgs_if.sv
rtl/adjacency_matrix_graph_store_core.sv
dv/adjacency_matrix_graph_store_core_tb.sv
